/* sv/dmsc_pkg.sv */
package dmsc_pkg;

    // Input item kinds
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_CONTROL   = 3'd1,
        OP_LEVEL     = 3'd2,
        OP_ADDRESS   = 3'd3,
        OP_LENGTH    = 3'd4,
        OP_ENABLE    = 3'd5,
        OP_BYTE      = 3'd6
    } dmsc_op_t;

    // Playback modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_LOOP   = 2'd1,
        MODE_IRQ    = 2'd2
    } dmsc_mode_t;

    localparam logic [15:0] ADDR_BASE       = 16'hC000;
    localparam logic [15:0] ADDR_WRAP_LAST  = 16'hFFFF;
    localparam logic [15:0] ADDR_WRAP_FIRST = 16'h8000;
    localparam logic [5:0]  LEVEL_MAX       = 6'h3F;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data;
    } dmsc_in_t;

    typedef struct packed {
        logic [6:0]  sample_level;
        logic        irq_flag;
        logic        active;
        logic        fetch_request;
        logic [15:0] fetch_address;
        logic [11:0] timer_period;
    } dmsc_out_t;

    typedef struct packed {
        dmsc_mode_t  play_mode;
        logic [11:0] period;
        logic [5:0]  level;
        logic        level_low_bit;
        logic [6:0]  output_value;
        logic [15:0] start_address;
        logic [15:0] current_address;
        logic [11:0] length_reload;
        logic [11:0] bytes_remaining;
        logic [3:0]  bit_count;
        logic [7:0]  shifter;
        logic        have_bits;
        logic        irq_pending;
    } dmsc_state_t;

    localparam dmsc_state_t STATE_RESET = '{
        play_mode:       MODE_NORMAL,
        period:          12'd0,
        level:           6'd0,
        level_low_bit:   1'b0,
        output_value:    7'd0,
        start_address:   16'd0,
        current_address: 16'd0,
        length_reload:   12'd0,
        bytes_remaining: 12'd0,
        bit_count:       4'd0,
        shifter:         8'd0,
        have_bits:       1'b0,
        irq_pending:     1'b0
    };

    // Timer period for each rate code
    function automatic logic [11:0] rate_lookup(input logic [3:0] rate);
        logic [11:0] p;
        unique case (rate)
            4'd0:    p = 12'hD60;
            4'd1:    p = 12'hBE0;
            4'd2:    p = 12'hAA0;
            4'd3:    p = 12'hA00;
            4'd4:    p = 12'h8F0;
            4'd5:    p = 12'h7F0;
            4'd6:    p = 12'h710;
            4'd7:    p = 12'h6B0;
            4'd8:    p = 12'h5F0;
            4'd9:    p = 12'h500;
            4'd10:   p = 12'h470;
            4'd11:   p = 12'h400;
            4'd12:   p = 12'h350;
            4'd13:   p = 12'h2A0;
            4'd14:   p = 12'h240;
            default: p = 12'h1B0;
        endcase
        return p;
    endfunction

endpackage

/* sv/dmsc_step.sv */
module dmsc_step
    import dmsc_pkg::*;
(
    input  dmsc_in_t    item,
    input  logic        output_enable,
    input  dmsc_state_t state,
    output dmsc_state_t state_next,
    output dmsc_out_t   result
);

    logic        req;
    logic [15:0] req_addr;
    logic [15:0] addr_tmp;
    logic [11:0] bytes_tmp;

    // Work out the channel update for one item
    always_comb
    begin
        state_next = state;
        req        = 1'b0;
        req_addr   = 16'd0;
        addr_tmp   = state.current_address;
        bytes_tmp  = state.bytes_remaining;

        unique case (item.opcode)
            OP_TICK:
            begin
                // shift one bit into the level, saturating at both ends
                if (state.have_bits)
                begin
                    if (state.shifter[0])
                    begin
                        if (state.level != LEVEL_MAX)
                            state_next.level = state.level + 6'd1;
                    end
                    else if (state.level != 6'd0)
                    begin
                        state_next.level = state.level - 6'd1;
                    end
                    state_next.output_value = output_enable
                        ? {state_next.level, state.level_low_bit} : 7'd0;
                    state_next.shifter = {1'b0, state.shifter[7:1]};
                end
                // end of byte: fetch the next one, reload or flag the end
                if (state.bit_count <= 4'd1)
                begin
                    state_next.have_bits = 1'b0;
                    if (bytes_tmp == 12'd0 && state.play_mode == MODE_LOOP)
                    begin
                        addr_tmp  = state.start_address;
                        bytes_tmp = state.length_reload;
                    end
                    if (bytes_tmp != 12'd0)
                    begin
                        req       = 1'b1;
                        req_addr  = addr_tmp;
                        bytes_tmp = bytes_tmp - 12'd1;
                        addr_tmp  = (addr_tmp == ADDR_WRAP_LAST)
                            ? ADDR_WRAP_FIRST : addr_tmp + 16'd1;
                        state_next.have_bits = 1'b1;
                        if (bytes_tmp == 12'd0 && state.play_mode == MODE_IRQ)
                            state_next.irq_pending = 1'b1;
                    end
                    state_next.current_address = addr_tmp;
                    state_next.bytes_remaining = bytes_tmp;
                    state_next.bit_count       = BITS_PER_BYTE;
                end
                else
                begin
                    state_next.bit_count = state.bit_count - 4'd1;
                end
            end
            OP_CONTROL:
            begin
                // loop wins when both mode bits are set
                if (item.data[6])
                    state_next.play_mode = MODE_LOOP;
                else if (item.data[7])
                    state_next.play_mode = MODE_IRQ;
                else
                    state_next.play_mode = MODE_NORMAL;
                if (!item.data[7])
                    state_next.irq_pending = 1'b0;
                state_next.period = rate_lookup(item.data[3:0]);
            end
            OP_LEVEL:
            begin
                state_next.level         = item.data[6:1];
                state_next.level_low_bit = item.data[0];
                if (output_enable)
                    state_next.output_value = item.data[6:0];
            end
            OP_ADDRESS:
            begin
                state_next.start_address   = ADDR_BASE | {2'b00, item.data, 6'b000000};
                state_next.current_address = ADDR_BASE | {2'b00, item.data, 6'b000000};
            end
            OP_LENGTH:
            begin
                state_next.length_reload   = {item.data, 4'b0000} + 12'd1;
                state_next.bytes_remaining = {item.data, 4'b0000} + 12'd1;
            end
            OP_ENABLE:
            begin
                if (item.data[4])
                begin
                    state_next.current_address = state.start_address;
                    state_next.bytes_remaining = state.length_reload;
                end
                else
                begin
                    state_next.bytes_remaining = 12'd0;
                end
                state_next.irq_pending = 1'b0;
            end
            OP_BYTE:
            begin
                state_next.shifter = item.data;
            end
            default:
            begin
                // unused code: leave the state alone
            end
        endcase
    end

    // Report the state after the item
    always_comb
    begin
        result.sample_level  = state_next.output_value;
        result.irq_flag      = state_next.irq_pending;
        result.active        = (state_next.bytes_remaining != 12'd0);
        result.fetch_request = req;
        result.fetch_address = req_addr;
        result.timer_period  = state_next.period;
    end

endmodule

/* sv/dmsc_out_reg.sv */
module dmsc_out_reg
    import dmsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  dmsc_out_t result,
    output logic      slot_free,
    output logic      out_valid,
    input  logic      out_ready,
    output dmsc_out_t out_item
);

    logic      out_valid_reg;
    logic      out_valid_next;
    dmsc_out_t out_item_reg;

    // The slot takes a new item when empty or being drained this cycle
    assign slot_free      = !out_valid_reg || out_ready;
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* sv/delta_modulation_sample_channel_core.sv */
// Delta-modulation sample playback channel.
// Input channel (in_valid/in_ready/in_item): one item per register write,
// channel tick or returned sample byte, chosen by in_item.opcode.
// Output channel (out_valid/out_ready/out_item): exactly one result item
// per input item, in order, carrying level, IRQ flag, active flag, fetch
// request with its address and the selected timer period.
// Configuration: cfg_write_en/cfg_write_data set the output enable at once;
// write it only while no item is in flight.
// An accepted item is held in the input register, and its result is loaded
// into the output register once that register has room. Throughput is one
// item per cycle while the receiver keeps up, set by the combinational state
// update between the input register and the result register.
// A stalled receiver holds the result register; the input register then
// fills and in_ready drops until the result is taken.
// Reset clears all channel state, empties both registers and sets the
// output enable to one.
module delta_modulation_sample_channel_core
    import dmsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dmsc_in_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output dmsc_out_t out_item,
    input  logic      cfg_write_en,
    input  logic      cfg_write_data
);

    logic        in_valid_reg;
    logic        in_valid_next;
    dmsc_in_t    in_item_reg;
    logic        output_enable_reg;
    dmsc_state_t state_reg;
    dmsc_state_t state_next;
    dmsc_out_t   result;
    logic        slot_free;
    logic        advance;
    logic        in_accept;

    // Move the held item into the result register when there is room
    assign advance       = in_valid_reg && slot_free;
    assign in_ready      = !in_valid_reg || advance;
    assign in_accept     = in_valid && in_ready;
    assign in_valid_next = in_accept || (in_valid_reg && !advance);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_item_reg <= in_item;
    end

    // Output enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            output_enable_reg <= 1'b1;
        else if (cfg_write_en)
            output_enable_reg <= cfg_write_data;
    end

    // Channel state, advanced once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    dmsc_step u_step (
        .item          (in_item_reg),
        .output_enable (output_enable_reg),
        .state         (state_reg),
        .state_next    (state_next),
        .result        (result)
    );

    dmsc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // An empty result slot never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low while the result slot is empty");

    // A held item is not dropped while it waits
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("held item lost while stalled");

    // Every item that advances shows up as a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced item produced no result");

    // An enabled level load reports the loaded level
    a_level_load: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.opcode == OP_LEVEL && output_enable_reg
        |=> out_item.sample_level == $past(in_item_reg.data[6:0]))
        else $error("level load not reflected in output");

    // An item without a fetch request reports address zero
    a_no_req_addr: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !result.fetch_request |=> out_item.fetch_address == 16'd0)
        else $error("fetch address set without a request");

endmodule

/* dv/dmsc_result_checker.sv */
`timescale 1ns / 1ps

module dmsc_result_checker
    import dmsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  dmsc_in_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  dmsc_out_t out_item,
    input  logic      cfg_write_en,
    input  logic      cfg_write_data,
    output int        fail_count,
    output int        waiting
);

    // Timer periods, rate code 0 in the low slice
    localparam logic [16*12-1:0] RATE_PERIODS = {
        12'h1B0, 12'h240, 12'h2A0, 12'h350, 12'h400, 12'h470, 12'h500, 12'h5F0,
        12'h6B0, 12'h710, 12'h7F0, 12'h8F0, 12'hA00, 12'hAA0, 12'hBE0, 12'hD60
    };

    dmsc_state_t chan;
    logic        level_enable;
    dmsc_out_t   expected_results [$];

    // Advance the channel copy by one item and return the result it gives
    function automatic dmsc_out_t step_channel(input dmsc_in_t item);
        dmsc_out_t   res;
        logic        req;
        logic [15:0] req_addr;
        req = 1'b0;
        req_addr = 16'd0;
        case (item.opcode)
            OP_TICK:
            begin
                if (chan.have_bits)
                begin
                    if (chan.shifter[0])
                    begin
                        if (chan.level < LEVEL_MAX)
                            chan.level = chan.level + 6'd1;
                    end
                    else if (chan.level != 6'd0)
                    begin
                        chan.level = chan.level - 6'd1;
                    end
                    chan.output_value = level_enable ? {chan.level, chan.level_low_bit} : 7'd0;
                    chan.shifter = chan.shifter >> 1;
                end
                if (chan.bit_count <= 4'd1)
                begin
                    chan.have_bits = 1'b0;
                    // Reload at the end of a looping sample
                    if (chan.bytes_remaining == 12'd0 && chan.play_mode == MODE_LOOP)
                    begin
                        chan.current_address = chan.start_address;
                        chan.bytes_remaining = chan.length_reload;
                    end
                    if (chan.bytes_remaining != 12'd0)
                    begin
                        req = 1'b1;
                        req_addr = chan.current_address;
                        chan.bytes_remaining = chan.bytes_remaining - 12'd1;
                        if (chan.current_address == ADDR_WRAP_LAST)
                            chan.current_address = ADDR_WRAP_FIRST;
                        else
                            chan.current_address = chan.current_address + 16'd1;
                        chan.have_bits = 1'b1;
                        if (chan.bytes_remaining == 12'd0 && chan.play_mode == MODE_IRQ)
                            chan.irq_pending = 1'b1;
                    end
                    chan.bit_count = BITS_PER_BYTE;
                end
                else
                begin
                    chan.bit_count = chan.bit_count - 4'd1;
                end
            end
            OP_CONTROL:
            begin
                // Loop bit wins over the IRQ bit
                if (item.data[6])
                    chan.play_mode = MODE_LOOP;
                else if (item.data[7])
                    chan.play_mode = MODE_IRQ;
                else
                    chan.play_mode = MODE_NORMAL;
                if (!item.data[7])
                    chan.irq_pending = 1'b0;
                chan.period = RATE_PERIODS[item.data[3:0]*12 +: 12];
            end
            OP_LEVEL:
            begin
                chan.level = item.data[6:1];
                chan.level_low_bit = item.data[0];
                if (level_enable)
                    chan.output_value = {chan.level, chan.level_low_bit};
            end
            OP_ADDRESS:
            begin
                chan.start_address = ADDR_BASE | {2'b00, item.data, 6'd0};
                chan.current_address = chan.start_address;
            end
            OP_LENGTH:
            begin
                chan.length_reload = {item.data, 4'd0} + 12'd1;
                chan.bytes_remaining = chan.length_reload;
            end
            OP_ENABLE:
            begin
                if (item.data[4])
                begin
                    chan.current_address = chan.start_address;
                    chan.bytes_remaining = chan.length_reload;
                end
                else
                begin
                    chan.bytes_remaining = 12'd0;
                end
                chan.irq_pending = 1'b0;
            end
            OP_BYTE:
                chan.shifter = item.data;
            default:
                ;
        endcase
        res.sample_level  = chan.output_value;
        res.irq_flag      = chan.irq_pending;
        res.active        = (chan.bytes_remaining != 12'd0);
        res.fetch_request = req;
        res.fetch_address = req_addr;
        res.timer_period  = chan.period;
        return res;
    endfunction

    // Compare one result item field by field
    task automatic compare_result(input dmsc_out_t want, input dmsc_out_t got);
        if (got.sample_level !== want.sample_level)
        begin
            $display("%0t: sample_level expected %0d, got %0d",
                     $time, want.sample_level, got.sample_level);
            fail_count++;
        end
        if (got.irq_flag !== want.irq_flag)
        begin
            $display("%0t: irq_flag expected %0d, got %0d", $time, want.irq_flag, got.irq_flag);
            fail_count++;
        end
        if (got.active !== want.active)
        begin
            $display("%0t: active expected %0d, got %0d", $time, want.active, got.active);
            fail_count++;
        end
        if (got.fetch_request !== want.fetch_request)
        begin
            $display("%0t: fetch_request expected %0d, got %0d",
                     $time, want.fetch_request, got.fetch_request);
            fail_count++;
        end
        if (got.fetch_address !== want.fetch_address)
        begin
            $display("%0t: fetch_address expected %h, got %h",
                     $time, want.fetch_address, got.fetch_address);
            fail_count++;
        end
        if (got.timer_period !== want.timer_period)
        begin
            $display("%0t: timer_period expected %h, got %h",
                     $time, want.timer_period, got.timer_period);
            fail_count++;
        end
    endtask

    // Watch both channels and the register port at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan = STATE_RESET;
            level_enable = 1'b1;
            expected_results.delete();
            fail_count = 0;
            waiting = 0;
        end
        else
        begin
            // Take the result first so an item accepted now cannot match it
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result item with none expected, got %h", $time, out_item);
                    fail_count++;
                end
                else
                begin
                    compare_result(expected_results.pop_front(), out_item);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(step_channel(in_item));
            if (cfg_write_en)
                level_enable = cfg_write_data;
            waiting = expected_results.size();
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dmsc_pkg::*;

    // Opcode that no register or tick decodes
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    dmsc_in_t  in_item;
    logic      out_valid;
    logic      out_ready;
    dmsc_out_t out_item;
    logic      cfg_write_en;
    logic      cfg_write_data;
    int        fail_count;
    int        waiting;

    bit        quiet;
    bit        byte_due;
    int        tick_phase;
    int        items_sent;
    int        phase;

    delta_modulation_sample_channel_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    dmsc_result_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fail_count     (fail_count),
        .waiting        (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the receiver at random outside quiet stretches
    always @(posedge clk)
    begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Offer one item, hold it until it is taken, and track the byte boundary
    task automatic send_item(input logic [2:0] op, input logic [7:0] d);
        while (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{opcode: op, data: d};
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        byte_due = 1'b0;
        if (op == OP_TICK)
        begin
            if (tick_phase <= 1)
            begin
                tick_phase = 8;
                byte_due = 1'b1;
            end
            else
            begin
                tick_phase--;
            end
        end
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Drop valid and wait until every result has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (waiting != 0);
        repeat (3) @(posedge clk);
    endtask

    // Write the output enable while idle, and set the idling mode
    task automatic reconfigure(input logic en, input bit q);
        wait_idle();
        quiet = q;
        cfg_write_en <= 1'b1;
        cfg_write_data <= en;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Run ticks, mostly answering each fetch with a byte, with odd register noise
    task automatic play_ticks(input int n);
        repeat (n)
        begin
            send_item(OP_TICK, 8'($urandom_range(255)));
            if (byte_due && $urandom_range(9) != 0)
                send_item(OP_BYTE, 8'($urandom_range(255)));
            if ($urandom_range(99) < 4)
                send_item(3'($urandom_range(1, 7)), 8'($urandom_range(255)));
        end
    endtask

    // Set up one sample and play it
    task automatic play_sample();
        logic [7:0] len;
        len = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        send_item(OP_CONTROL, 8'($urandom_range(255)));
        send_item(OP_ADDRESS, 8'($urandom_range(255)));
        send_item(OP_LENGTH, len);
        if ($urandom_range(1))
            send_item(OP_LEVEL, 8'($urandom_range(255)));
        send_item(OP_ENABLE, 8'($urandom_range(255)) | 8'h10);
        play_ticks($urandom_range(20, 250));
    endtask

    initial
    begin
        #400000;
        $display("delta_modulation_sample_channel_core test failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = 1'b1;
        quiet = 1'b0;
        byte_due = 1'b0;
        tick_phase = 0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, stray byte, unused opcode, both mode bits
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_CONTROL, 8'hC0);
        // One-byte IRQ sample at the top of memory, saturating both ways
        send_item(OP_CONTROL, 8'h8F);
        send_item(OP_ADDRESS, 8'hFF);
        send_item(OP_LENGTH, 8'h00);
        send_item(OP_LEVEL, 8'hFF);
        send_item(OP_ENABLE, 8'h10);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_item(OP_LEVEL, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_TICK, 8'h00);
        // Clear the interrupt, stop, longest length, restart mid-sample
        send_item(OP_CONTROL, 8'h0F);
        send_item(OP_ADDRESS, 8'h00);
        send_item(OP_LENGTH, 8'hFF);
        send_item(OP_ENABLE, 8'hEF);
        send_item(OP_ENABLE, 8'hFF);
        send_item(OP_TICK, 8'h55);
        send_item(OP_CONTROL, 8'h4D);
        send_item(OP_ENABLE, 8'h00);

        // Random phases; the first loops across the address wrap, the third runs
        // without any idling
        phase = 0;
        while (items_sent < 1000)
        begin
            if (phase == 1 || phase == 2 || (phase > 3 && phase % 3 == 1))
                reconfigure((phase == 1) ? 1'b0 : (phase == 2) ? 1'b1 : 1'($urandom_range(1)),
                            phase == 2);
            if (phase == 0)
            begin
                send_item(OP_CONTROL, 8'h40 | 8'($urandom_range(15)));
                send_item(OP_ADDRESS, 8'hFF);
                send_item(OP_LENGTH, 8'h04);
                send_item(OP_ENABLE, 8'h10);
                play_ticks(560);
            end
            else if (phase == 2 || $urandom_range(99) < 80)
            begin
                play_sample();
            end
            else
            begin
                repeat (12) send_item(3'($urandom_range(7)), 8'($urandom_range(255)));
            end
            phase++;
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("delta_modulation_sample_channel_core test passed");
        else
            $display("delta_modulation_sample_channel_core test failed");
        $finish;
    end

endmodule
